// File: src/rbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RBF kernel package
// Shared widths, types, register codes and the exp(-y) lookup table builder.
// ----------------------------------------------------------------------------
package rbf_pkg;

   localparam int MAX_DIMS        = 64;
   localparam int EXP_TABLE_DEPTH = 1024;
   localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);

   localparam int COORD_W    = 16;
   localparam int SQ_W       = 32;
   localparam int ACC_W      = 40;
   localparam int PARAM_W    = 24;
   localparam int ENTRY_W    = 16;
   localparam int Y_W        = 64;
   localparam int Y_FRAC_W   = 44;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PARAM_W-1:0] COEF_RESET = 24'd32768;
   localparam logic [PARAM_W-1:0] VAR_RESET  = 24'd65536;

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HALF_INV_LEN_SQ = 1'b0,
      CSR_SIGNAL_VARIANCE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ACC_W-1:0] distance;
      logic             sat;
   } dist_entry_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_PART,
      BACK_INDEX,
      BACK_LOOKUP,
      BACK_SCALE,
      BACK_EMIT
   } back_state_type;

   typedef logic [ENTRY_W-1:0] exp_rom_type [EXP_TABLE_DEPTH];

   // Entry i holds exp(-16 * i / depth) in Q1.15, built from a truncated
   // Taylor series for the step ratio and repeated rounded multiplication.
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type  rom;
      logic [127:0] step;
      logic [127:0] term;
      logic [127:0] ratio;
      logic [127:0] p;
      step  = (128'd16 << 32) / EXP_TABLE_DEPTH;
      term  = 128'd1 << 32;
      ratio = 128'd1 << 32;
      p     = 128'd1 << 32;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * step) >> 32) / 128'(k);
         if ((k & 1) == 1) begin
            ratio = ratio - term;
         end else begin
            ratio = ratio + term;
         end
      end
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         if (i > 0) begin
            p = (p * ratio + (128'd1 << 31)) >> 32;
         end
         rom[i] = ENTRY_W'((p + (128'd1 << 16)) >> 17);
      end
      return rom;
   endfunction

endpackage

// File: src/rbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RBF front end
// Squares each coordinate difference and accumulates the squared distance,
// handing the finished distance of each point pair to the queue.
// ----------------------------------------------------------------------------
module rbf_front
   import rbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_query_coord,
   input  logic [COORD_W-1:0]  req_rated_coord,
   input  logic                req_last_coord,
   output logic                push_valid,
   input  logic                push_ready,
   output dist_entry_type      push_data
);

   logic              sq_valid_ff;
   logic              sq_valid_in;
   logic [SQ_W-1:0]   sq_ff;
   logic [SQ_W-1:0]   sq_in;
   logic              sq_last_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic              sat_ff;
   logic              sat_in;
   logic              advance;
   logic              fire;
   logic signed [COORD_W:0] diff;
   logic [COORD_W-1:0] mag;
   logic [ACC_W:0]     sum;
   logic [ACC_W-1:0]   acc_next;
   logic               sat_next;

   always_comb begin
      diff = $signed({req_query_coord[COORD_W-1], req_query_coord})
             - $signed({req_rated_coord[COORD_W-1], req_rated_coord});
      mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      sq_in = SQ_W'(mag) * SQ_W'(mag);

      sum = {1'b0, acc_ff} + (ACC_W + 1)'(sq_ff);
      if (sum[ACC_W]) begin
         acc_next = '1;
         sat_next = 1'b1;
      end else begin
         acc_next = sum[ACC_W-1:0];
         sat_next = sat_ff;
      end

      advance     = !sq_valid_ff || !sq_last_ff || push_ready;
      fire        = sq_valid_ff && advance;
      req_ready   = advance;
      sq_valid_in = req_valid || (sq_valid_ff && !advance);

      push_valid         = sq_valid_ff && sq_last_ff;
      push_data.distance = acc_next;
      push_data.sat      = sat_next;

      acc_in = acc_ff;
      sat_in = sat_ff;
      if (fire) begin
         if (sq_last_ff) begin
            acc_in = '0;
            sat_in = 1'b0;
         end else begin
            acc_in = acc_next;
            sat_in = sat_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         acc_ff      <= '0;
         sat_ff      <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         acc_ff      <= acc_in;
         sat_ff      <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff      <= sq_in;
         sq_last_ff <= req_last_coord;
      end
   end

endmodule

// File: src/rbf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RBF distance queue
// A short first-in first-out buffer of finished distances between the
// front end and the back end.
// ----------------------------------------------------------------------------
module rbf_queue
   import rbf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  dist_entry_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output dist_entry_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dist_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = slot_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/rbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RBF back end
// Scales a finished distance, looks up exp(-y) in the table and multiplies
// by the variance, one point pair at a time.
// ----------------------------------------------------------------------------
module rbf_back
   import rbf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [PARAM_W-1:0]  half_inv_len_sq,
   input  logic [PARAM_W-1:0]  signal_variance,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  dist_entry_type      pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PARAM_W-1:0]  rsp_kernel_value,
   output logic                rsp_saturated
);

   localparam exp_rom_type EXP_ROM = build_exp_rom();
   localparam int IDX_PROD_W = Y_FRAC_W + EXP_IDX_W + 1;
   localparam int PLO_W = 2 * PARAM_W;
   localparam int PHI_W = (ACC_W - PARAM_W) + PARAM_W;
   localparam int PROD_W = PARAM_W + ENTRY_W;

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [ACC_W-1:0]    dist_ff;
   logic                sat_ff;
   logic                sat_in;
   logic [PLO_W-1:0]    plo_ff;
   logic [PHI_W-1:0]    phi_ff;
   logic [EXP_IDX_W-1:0] idx_ff;
   logic [EXP_IDX_W-1:0] idx_in;
   logic [ENTRY_W-1:0]  entry_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [PARAM_W-1:0]  kernel_ff;
   logic                rsp_sat_ff;
   logic                load_dist;
   logic                load_rsp;
   logic [Y_W-1:0]      y;
   logic                ysat;
   logic [IDX_PROD_W-1:0] idx_round;
   logic [EXP_IDX_W:0]  idx_raw;
   logic [PROD_W:0]     kv_sum;
   logic [PROD_W-15:0]  kv_shift;
   logic [PARAM_W-1:0]  kv;

   always_comb begin
      y = {phi_ff, {PARAM_W{1'b0}}} + Y_W'(plo_ff);
      ysat = |y[Y_W-1:Y_FRAC_W];
      idx_round = IDX_PROD_W'(y[Y_FRAC_W-1:0]) * IDX_PROD_W'(EXP_TABLE_DEPTH)
                  + (IDX_PROD_W'(1) << (Y_FRAC_W - 1));
      idx_raw = idx_round[IDX_PROD_W-1:Y_FRAC_W];
      if (ysat || idx_raw > (EXP_IDX_W + 1)'(EXP_TABLE_DEPTH - 1)) begin
         idx_in = EXP_IDX_W'(EXP_TABLE_DEPTH - 1);
      end else begin
         idx_in = idx_raw[EXP_IDX_W-1:0];
      end

      kv_sum   = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(1 << 14);
      kv_shift = kv_sum[PROD_W:15];
      kv       = (|kv_shift[PROD_W-15:PARAM_W]) ? '1 : kv_shift[PARAM_W-1:0];

      state_in     = state_ff;
      pop_ready    = 1'b0;
      load_dist    = 1'b0;
      load_rsp     = 1'b0;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               load_dist = 1'b1;
               state_in  = BACK_PART;
            end
         end
         BACK_PART: begin
            state_in = BACK_INDEX;
         end
         BACK_INDEX: begin
            sat_in   = sat_ff | ysat;
            state_in = BACK_LOOKUP;
         end
         BACK_LOOKUP: begin
            state_in = BACK_SCALE;
         end
         BACK_SCALE: begin
            state_in = BACK_EMIT;
         end
         BACK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_dist) begin
         dist_ff <= pop_data.distance;
         sat_ff  <= pop_data.sat;
      end else begin
         sat_ff  <= sat_in;
      end
      plo_ff   <= PLO_W'(dist_ff[PARAM_W-1:0]) * PLO_W'(half_inv_len_sq);
      phi_ff   <= PHI_W'(dist_ff[ACC_W-1:PARAM_W]) * PHI_W'(half_inv_len_sq);
      idx_ff   <= idx_in;
      entry_ff <= EXP_ROM[idx_ff];
      prod_ff  <= PROD_W'(signal_variance) * PROD_W'(entry_ff);
      if (load_rsp) begin
         kernel_ff  <= kv;
         rsp_sat_ff <= sat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = kernel_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

// File: src/rbf_kernel_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian RBF kernel entry
// Streams coordinate pairs and returns variance * exp(-coef * |q - r|^2).
// ----------------------------------------------------------------------------
// The front end takes one coordinate pair per cycle, unless a finished
// distance waits for room in the queue, and adds its squared difference to a
// saturating distance accumulator. A pair marked as the last coordinate
// closes the point pair and its distance joins a two-entry queue. The back
// end then works through each point pair in turn (two partial products,
// index, table read, variance product, result) and takes no new distance
// until it has handed the result to its output register.
// Configuration writes are taken in every cycle and must only happen while
// the block is idle.
// ----------------------------------------------------------------------------
module rbf_kernel_entry
   import rbf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_W-1:0]     req_query_coord,
   input  logic [COORD_W-1:0]     req_rated_coord,
   input  logic                   req_last_coord,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PARAM_W-1:0]     rsp_kernel_value,
   output logic                   rsp_saturated,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PARAM_W-1:0]     csr_data
);

   logic [PARAM_W-1:0] coef_ff;
   logic [PARAM_W-1:0] var_ff;
   logic               push_valid;
   logic               push_ready;
   dist_entry_type     push_data;
   logic               pop_valid;
   logic               pop_ready;
   dist_entry_type     pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
         var_ff  <= VAR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_HALF_INV_LEN_SQ: coef_ff <= csr_data;
            CSR_SIGNAL_VARIANCE: var_ff  <= csr_data;
         endcase
      end
   end

   rbf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_query_coord (req_query_coord),
      .req_rated_coord (req_rated_coord),
      .req_last_coord  (req_last_coord),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   rbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rbf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .half_inv_len_sq  (coef_ff),
      .signal_variance  (var_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kernel_value (rsp_kernel_value),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Gaussian RBF kernel entry
// Streams coordinate pairs through the block and compares each kernel value
// and its saturation flag with a cycle-free model held in the testbench. The
// model keeps its own distance sum, register copies and exp(-y) table. Both
// channels idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import rbf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 730;
   localparam int ARG_FRAC_W   = 40;
   localparam int INDEX_SHIFT  = ARG_FRAC_W + 4;
   localparam logic [ACC_W-1:0]   DIST_MAX  = '1;
   localparam logic [63:0]        ARG_LIMIT = 64'd16 << ARG_FRAC_W;
   localparam logic [PARAM_W-1:0] PARAM_MAX = '1;

   typedef struct {
      logic [PARAM_W-1:0] value;
      logic               sat;
   } kernel_result_type;

   typedef enum int {RX_OPEN, RX_PERIODIC, RX_COIN, RX_SPARSE} rx_mode_type;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [COORD_W-1:0]   req_query_coord = '0;
   logic [COORD_W-1:0]   req_rated_coord = '0;
   logic                 req_last_coord  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic [PARAM_W-1:0]   rsp_kernel_value;
   logic                 rsp_saturated;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index       = CSR_HALF_INV_LEN_SQ;
   logic [PARAM_W-1:0]   csr_data        = '0;

   logic [ENTRY_W-1:0]   exp_lut [EXP_TABLE_DEPTH];
   logic [ACC_W-1:0]     dist_sum        = '0;
   logic                 dist_overflowed = 1'b0;
   logic [PARAM_W-1:0]   coef_setting    = COEF_RESET;
   logic [PARAM_W-1:0]   var_setting     = VAR_RESET;
   kernel_result_type    pending_kernels [$];

   int                   fault_count = 0;
   int                   cycle_count = 0;
   int                   burst_left  = 0;
   int                   hold_cycles = 0;

   rbf_kernel_entry uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_query_coord  (req_query_coord),
      .req_rated_coord  (req_rated_coord),
      .req_last_coord   (req_last_coord),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kernel_value (rsp_kernel_value),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Entry i approximates exp(-16 * i / depth) in Q1.15.
   function automatic void build_exp_lut();
      logic [63:0] step;
      logic [63:0] term;
      logic [63:0] ratio;
      logic [63:0] power;
      step  = (64'd16 << 32) / EXP_TABLE_DEPTH;
      term  = 64'd1 << 32;
      ratio = term;
      power = term;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * step) >> 32) / 64'(k);
         ratio = (k % 2 == 1) ? ratio - term : ratio + term;
      end
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         if (i > 0) begin
            power = (power * ratio + (64'd1 << 31)) >> 32;
         end
         exp_lut[i] = ENTRY_W'((power + (64'd1 << 16)) >> 17);
      end
   endfunction

   function automatic kernel_result_type kernel_of_pair(logic [ACC_W-1:0] dist_total,
                                                        logic acc_sat);
      logic [63:0]       arg;
      logic [63:0]       slot;
      logic [63:0]       scaled;
      logic              arg_sat;
      kernel_result_type res;
      arg = 64'(dist_total) * 64'(coef_setting);
      arg_sat = (arg >= ARG_LIMIT);
      if (arg_sat) begin
         slot = 64'(EXP_TABLE_DEPTH - 1);
      end else begin
         slot = (arg * EXP_TABLE_DEPTH + (64'd1 << (INDEX_SHIFT - 1))) >> INDEX_SHIFT;
         if (slot > 64'(EXP_TABLE_DEPTH - 1)) begin
            slot = 64'(EXP_TABLE_DEPTH - 1);
         end
      end
      scaled = (64'(var_setting) * 64'(exp_lut[slot]) + (64'd1 << 14)) >> 15;
      res.value = (scaled > 64'(PARAM_MAX)) ? PARAM_MAX : scaled[PARAM_W-1:0];
      res.sat = acc_sat | arg_sat;
      return res;
   endfunction

   function automatic void accumulate_coord(logic signed [COORD_W-1:0] q,
                                            logic signed [COORD_W-1:0] r,
                                            logic last);
      longint diff;
      logic [63:0] total;
      diff = longint'(q) - longint'(r);
      total = 64'(dist_sum) + 64'(diff * diff);
      if (total > 64'(DIST_MAX)) begin
         dist_sum = DIST_MAX;
         dist_overflowed = 1'b1;
      end else begin
         dist_sum = total[ACC_W-1:0];
      end
      if (last) begin
         pending_kernels.push_back(kernel_of_pair(dist_sum, dist_overflowed));
         dist_sum = '0;
         dist_overflowed = 1'b0;
      end
   endfunction

   task automatic send_coord(logic signed [COORD_W-1:0] q,
                             logic signed [COORD_W-1:0] r,
                             logic last);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid       <= 1'b1;
      req_query_coord <= q;
      req_rated_coord <= r;
      req_last_coord  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accumulate_coord(q, r, last);
      burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_kernels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(logic [PARAM_W-1:0] coef, logic [PARAM_W-1:0] amp);
      csr_valid <= 1'b1;
      csr_index <= CSR_HALF_INV_LEN_SQ;
      csr_data  <= coef;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      coef_setting = coef;
      csr_index <= CSR_SIGNAL_VARIANCE;
      csr_data  <= amp;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      var_setting = amp;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_pair(int dims);
      logic signed [COORD_W-1:0] q;
      logic signed [COORD_W-1:0] r;
      int  offs;
      int  sh;
      bit  wide;
      wide = ($urandom_range(0, 2) == 0);
      sh = $urandom_range(0, 14);
      for (int i = 0; i < dims; i++) begin
         q = COORD_W'($urandom);
         if (wide) begin
            r = COORD_W'($urandom);
         end else begin
            offs = int'($urandom_range(0, (1 << sh) - 1));
            if ($urandom_range(0, 1) == 1) begin
               offs = -offs;
            end
            r = COORD_W'(int'(q) + offs);
         end
         send_coord(q, r, i == dims - 1);
      end
   endtask

   function automatic int pick_dims();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return $urandom_range(1, 4);
      end else if (roll < 85) begin
         return $urandom_range(5, 16);
      end else if (roll < 97) begin
         return $urandom_range(17, MAX_DIMS);
      end
      return $urandom_range(MAX_DIMS + 1, MAX_DIMS + 16);
   endfunction

   task automatic test_directed();
      send_coord(0, 0, 1'b1);
      send_coord(32767, -32768, 1'b1);
      send_coord(-32768, 32767, 1'b1);
      send_coord(-32768, -32768, 1'b1);
      send_coord(23170, 0, 1'b1);
      send_coord(0, -23171, 1'b1);
      send_coord(1, 0, 1'b1);
      send_coord(100, -100, 1'b0);
      send_coord(4096, 0, 1'b0);
      send_coord(-4096, 4096, 1'b1);
      send_coord(0, 0, 1'b0);
      send_coord(32767, 32767, 1'b1);
      pause_sender();
   endtask

   task automatic test_config_extremes();
      logic [PARAM_W-1:0] coefs [7];
      logic [PARAM_W-1:0] amps  [7];
      coefs = '{24'd0, 24'd0, PARAM_MAX, PARAM_MAX, 24'd1, COEF_RESET, 24'd65536};
      amps  = '{24'd0, PARAM_MAX, PARAM_MAX, 24'd0, 24'd1, VAR_RESET, PARAM_MAX};
      for (int s = 0; s < 7; s++) begin
         load_settings(coefs[s], amps[s]);
         send_coord(-20000, -20000, 1'b1);
         for (int p = 0; p < 4; p++) begin
            send_random_pair($urandom_range(1, 3));
         end
         pause_sender();
      end
   endtask

   task automatic test_long_pairs();
      load_settings(24'd0, PARAM_MAX);
      for (int i = 0; i < 258; i++) begin
         send_coord(32767, -32768, i == 257);
      end
      pause_sender();
      load_settings(24'd2000, VAR_RESET);
      for (int i = 0; i < 80; i++) begin
         send_coord(COORD_W'($urandom_range(0, 511)), 0, i == 79);
      end
      send_random_pair(MAX_DIMS + 6);
      pause_sender();
   endtask

   task automatic test_backpressure();
      load_settings(24'd4096, VAR_RESET);
      hold_cycles = 400;
      for (int i = 0; i < 40; i++) begin
         send_random_pair(1);
      end
      pause_sender();
   endtask

   task automatic test_random_pairs();
      int sent;
      int next_reload;
      int dims;
      logic [PARAM_W-1:0] coef;
      logic [PARAM_W-1:0] amp;
      sent = 0;
      next_reload = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_reload) begin
            pause_sender();
            case ($urandom_range(0, 4))
               0:       coef = PARAM_W'($urandom_range(0, 65535));
               1:       coef = PARAM_W'($urandom_range(0, 4095));
               2:       coef = PARAM_W'($urandom);
               3:       coef = COEF_RESET;
               default: coef = PARAM_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
               0:       amp = VAR_RESET;
               1:       amp = PARAM_MAX;
               default: amp = PARAM_W'($urandom);
            endcase
            load_settings(coef, amp);
            next_reload = sent + $urandom_range(150, 350);
         end
         dims = pick_dims();
         sent += dims;
         send_random_pair(dims);
      end
      pause_sender();
   endtask

   initial begin : receiver
      rx_mode_type mode;
      int          left;
      mode = RX_OPEN;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
               RX_OPEN:     rsp_ready <= 1'b1;
               RX_PERIODIC: rsp_ready <= (left % 4 != 0);
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               default:     rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      kernel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_kernels.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("unexpected transfer: value %0d sat %0b",
                        rsp_kernel_value, rsp_saturated);
            end
         end else begin
            want = pending_kernels.pop_front();
            if (rsp_kernel_value !== want.value || rsp_saturated !== want.sat) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: expected value %0d sat %0b, got value %0d sat %0b",
                           want.value, want.sat, rsp_kernel_value, rsp_saturated);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[rbf_kernel_entry] ERROR");
         $finish;
      end
   end

   initial begin
      build_exp_lut();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_long_pairs();
      test_backpressure();
      test_random_pairs();
      if (fault_count == 0 && pending_kernels.size() == 0) begin
         $display("[rbf_kernel_entry] OK");
      end else begin
         $display("[rbf_kernel_entry] ERROR");
      end
      $finish;
   end

endmodule

// File: rbf_kernel_entry.f
src/rbf_pkg.sv
src/rbf_front.sv
src/rbf_queue.sv
src/rbf_back.sv
src/rbf_kernel_entry.sv
sim/tb_top.sv
